[sv/rce_pkg.sv]
// Package: constants and types for the RGB 3x3 convolution block.
`default_nettype none
package rce_pkg;
  localparam int MaxWidth  = 2048;
  localparam int CoefBits  = 16;
  localparam int FracBits  = CoefBits - 4;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = 16;
  localparam logic [15:0] RowCap = 16'hFFFF;

  typedef logic [23:0] pix_t;
  typedef logic signed [CoefBits-1:0] coef_t;

  // Window column handed from cell to cell: top, middle, bottom pixel.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } wcol_t;

  // Per-item control handed down the pipeline.
  typedef struct packed {
    logic emit;
    logic last;
    logic pass;
    logic c0_edge;
    logic c2_edge;
    logic r0_edge;
    logic r2_edge;
  } ctl_t;

  localparam int SumW = 8 + CoefBits + 4;
  typedef logic signed [SumW-1:0] sum_t;

  function automatic coef_t coef_field(input logic [47:0] reg_v, input int k);
    logic [CoefBits-1:0] f;
    f = reg_v[k*CoefBits +: CoefBits];
    return coef_t'(f);
  endfunction

  function automatic logic [7:0] clamp_sum(input sum_t s);
    sum_t v;
    v = s >>> FracBits;
    if (s < 0) return 8'd0;
    if (v > sum_t'(255)) return 8'd255;
    return v[7:0];
  endfunction
endpackage
`default_nettype wire

[sv/rgb_conv3x3_edge_clamp.sv]
// Top level: streaming RGB 3x3 convolution with replicated borders.
//
//  channel | direction | payload
//  in_     | input     | kind, red_in, green_in, blue_in
//  out_    | output    | red_out, green_out, blue_out, frame_last
//  cfg_    | input     | cfg_index, cfg_data
//
// One item per cycle while the pipeline advances. A result leaves through the
// line store read, window shift and multiply register after the item that
// releases it (the sum and clamp follow the multiply register), W+1 items after
// its pixel. The whole pipeline advances only when the output register is free
// or being taken. Reset clears counters and valids; line stores stay.
`default_nettype none
module rgb_conv3x3_edge_clamp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_frame_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  import rce_pkg::*;

  typedef enum logic [2:0] {
    REG_WIDTH = 3'd0, REG_HEIGHT = 3'd1, REG_LEFT = 3'd2, REG_MID = 3'd3, REG_RIGHT = 3'd4
  } reg_idx_t;

  logic [11:0] width_r;
  logic [12:0] height_r;
  logic [47:0] coef_l_r, coef_m_r, coef_r_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 13'd480;
      coef_l_r <= 48'd0;
      coef_m_r <= 48'd268435456;
      coef_r_r <= 48'd0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data[11:0];
        REG_HEIGHT: height_r <= cfg_data[12:0];
        REG_LEFT:   coef_l_r <= cfg_data;
        REG_MID:    coef_m_r <= cfg_data;
        REG_RIGHT:  coef_r_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [12:0] w_eff;
  logic [12:0] h_eff;
  always_comb begin
    w_eff = {1'b0, width_r};
    if (width_r == 12'd0) w_eff = 13'd1;
    else if ({1'b0, width_r} > 13'(MaxWidth)) w_eff = 13'(MaxWidth);
    h_eff = (height_r == 13'd0) ? 13'd1 : height_r;
  end

  // pipeline advance
  logic adv;
  logic v1_r, v2_r, v3_r;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = v3_r;

  logic acc_in;
  assign acc_in = in_valid && in_ready;

  // position counters
  logic [ColW:0]   in_col_r, out_col_r;
  logic [RowW-1:0] in_row_r, out_row_r;
  logic            take, emit, last;
  logic [ColW:0]   in_col_nxt, out_col_nxt;
  logic [RowW-1:0] in_row_nxt, out_row_nxt;
  pix_t            pixel;
  logic [ColW-1:0] x;

  assign take  = acc_in && !(in_kind && in_col_r == '0 && in_row_r == '0);
  assign pixel = in_kind ? 24'd0 : {in_red_in, in_green_in, in_blue_in};
  assign x     = (in_col_r >= (ColW+1)'(MaxWidth)) ? ColW'(MaxWidth - 1) : in_col_r[ColW-1:0];
  assign emit  = (in_row_r > 16'd1) || (in_row_r == 16'd1 && in_col_r >= 1);
  assign last  = ({3'd0, out_row_r} >= 19'(h_eff) - 19'd1) &&
                 ({1'b0, out_col_r} >= 13'(w_eff) - 13'd1);

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (take) begin
      in_col_nxt = in_col_r + 1'b1;
      if (13'(in_col_nxt) >= w_eff) begin
        in_col_nxt = '0;
        if (in_row_r < RowCap) in_row_nxt = in_row_r + 1'b1;
      end
      if (emit) begin
        if (last) begin
          in_col_nxt = '0; in_row_nxt = '0; out_col_nxt = '0; out_row_nxt = '0;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
          if (13'(out_col_nxt) >= w_eff) begin
            out_col_nxt = '0;
            if (out_row_r < RowCap) out_row_nxt = out_row_r + 1'b1;
          end
        end
      end
    end
  end

  ctl_t ctl0, ctl1_r, ctl2_r;
  always_comb begin
    ctl0.emit    = emit;
    ctl0.last    = last;
    ctl0.pass    = h_eff < 13'd6;
    ctl0.c0_edge = out_col_r == '0;
    ctl0.c2_edge = {1'b0, out_col_r} >= 13'(w_eff) - 13'd1;
    ctl0.r0_edge = out_row_r == '0;
    ctl0.r2_edge = {3'd0, out_row_r} >= 19'(h_eff) - 19'd1;
  end

  // line stores, read-before-write at the same address
  pix_t up_mem [MaxWidth];
  pix_t lo_mem [MaxWidth];
  pix_t top_r, mid_r, pix_r;
  always_ff @(posedge clk) begin
    if (take) begin
      top_r <= up_mem[x];
      mid_r <= lo_mem[x];
      up_mem[x] <= lo_mem[x];
      lo_mem[x] <= pixel;
      pix_r <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0;
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      in_col_r <= in_col_nxt; in_row_r <= in_row_nxt;
      out_col_r <= out_col_nxt; out_row_r <= out_row_nxt;
      if (adv) begin
        v1_r <= take;
        v2_r <= v1_r && ctl1_r.emit;
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) ctl1_r <= ctl0;
    if (adv && v1_r) ctl2_r <= ctl1_r;
  end

  // chain of window cells: newest column enters cell 2
  wcol_t [2:0] wc;
  wcol_t       newcol;
  logic        shift_en;
  assign newcol   = '{top: top_r, mid: mid_r, bot: pix_r};
  assign shift_en = adv && v1_r;

  rce_cell u_c2 (.clk(clk), .en(shift_en), .col_in(newcol), .col_out(wc[2]));
  rce_cell u_c1 (.clk(clk), .en(shift_en), .col_in(wc[2]), .col_out(wc[1]));
  rce_cell u_c0 (.clk(clk), .en(shift_en), .col_in(wc[1]), .col_out(wc[0]));

  // tap selection with edge replication
  coef_t [8:0] cf;
  logic [8:0][7:0] pr, pg, pb;
  always_comb begin
    wcol_t cs;
    pix_t  p;
    for (int i = 0; i < 3; i++) begin
      if (i == 0) cs = ctl2_r.c0_edge ? wc[1] : wc[0];
      else if (i == 1) cs = wc[1];
      else cs = ctl2_r.c2_edge ? wc[1] : wc[2];
      for (int j = 0; j < 3; j++) begin
        if (j == 0) p = ctl2_r.r0_edge ? cs.mid : cs.top;
        else if (j == 1) p = cs.mid;
        else p = ctl2_r.r2_edge ? cs.mid : cs.bot;
        pr[i*3+j] = p[23:16];
        pg[i*3+j] = p[15:8];
        pb[i*3+j] = p[7:0];
      end
      cf[i*3+0] = coef_field(i == 0 ? coef_l_r : (i == 1 ? coef_m_r : coef_r_r), 0);
      cf[i*3+1] = coef_field(i == 0 ? coef_l_r : (i == 1 ? coef_m_r : coef_r_r), 1);
      cf[i*3+2] = coef_field(i == 0 ? coef_l_r : (i == 1 ? coef_m_r : coef_r_r), 2);
    end
  end

  logic last3_r;
  always_ff @(posedge clk) begin
    if (adv) last3_r <= ctl2_r.last;
  end

  rce_mac u_r (.clk(clk), .en(adv), .px(pr), .cf(cf), .pass(ctl2_r.pass), .res(out_red_out));
  rce_mac u_g (.clk(clk), .en(adv), .px(pg), .cf(cf), .pass(ctl2_r.pass), .res(out_green_out));
  rce_mac u_b (.clk(clk), .en(adv), .px(pb), .cf(cf), .pass(ctl2_r.pass), .res(out_blue_out));
  assign out_frame_last = last3_r;
endmodule
`default_nettype wire

[sv/rce_cell.sv]
// One window cell: holds a column of the 3x3 window and hands it on.
`default_nettype none
module rce_cell (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire rce_pkg::wcol_t col_in,
  output rce_pkg::wcol_t      col_out
);
  import rce_pkg::*;
  wcol_t col_r;
  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= col_in;
    end
  end
  assign col_out = col_r;
endmodule
`default_nettype wire

[sv/rce_mac.sv]
// One channel of the 3x3 weighted sum, one register stage, with clamp.
`default_nettype none
module rce_mac (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [8:0][7:0]       px,
  input  wire rce_pkg::coef_t [8:0]  cf,
  input  wire logic                  pass,
  output logic [7:0]                 res
);
  import rce_pkg::*;
  sum_t [8:0] prod_r;
  logic       pass_r;
  logic [7:0] mid_r;
  sum_t       acc;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= sum_t'($signed({1'b0, px[i]}) * cf[i]);
      end
      pass_r <= pass;
      mid_r  <= px[4];
    end
  end
  always_comb begin
    acc = '0;
    for (int i = 0; i < 9; i++) acc = acc + prod_r[i];
  end
  assign res = pass_r ? mid_r : clamp_sum(acc);
endmodule
`default_nettype wire

[sim/rgb_conv3x3_edge_clamp_tb.sv]
// Testbench for rgb_conv3x3_edge_clamp: directed frames and random frames checked by a predictor.
`timescale 1ns / 100ps
`default_nettype none
module rgb_conv3x3_edge_clamp_tb;
  import rce_pkg::*;

  localparam logic [2:0] REG_WIDTH = 3'd0, REG_HEIGHT = 3'd1, REG_COEF_L = 3'd2,
                         REG_COEF_M = 3'd3, REG_COEF_R = 3'd4;
  localparam bit KIND_PIXEL = 1'b0, KIND_FLUSH = 1'b1;
  localparam logic [47:0] COEF_ID = 48'h0000_1000_0000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } res_t;

  typedef struct packed {
    bit         kind;
    logic [7:0] r, g, b;
    bit         has_exp;
    res_t       exp;
  } row_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, in_kind = 1'b0;
  logic [7:0] in_red_in = '0, in_green_in = '0, in_blue_in = '0;
  logic in_ready, out_valid, out_frame_last, cfg_ready;
  logic out_ready = 1'b0;
  logic [7:0] out_red_out, out_green_out, out_blue_out;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  rgb_conv3x3_edge_clamp uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [23:0] store_up[MaxWidth], store_lo[MaxWidth], win[9];
  int unsigned icol, irow, ocol, orow;
  logic [11:0] cur_w;
  logic [12:0] cur_h;
  logic [47:0] coef_l, coef_m, coef_r;

  res_t pixq[$];
  int errors = 0, items_sent = 0;
  bit quiet = 0, long_hold = 0;

  function automatic bit conv_step(input bit flush, input logic [23:0] pin, output res_t res);
    int unsigned w, h, x;
    logic [23:0] px, top, mid;
    int cols[3], rows[3];
    logic [47:0] regs[3];
    longint s;
    logic [7:0] ch[3];
    bit last;
    w = cur_w;
    if (w == 0) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    h = cur_h;
    if (h == 0) h = 1;
    res = '0;
    if (flush && icol == 0 && irow == 0) return 0;
    px = flush ? 24'd0 : pin;
    x = icol < MaxWidth ? icol : MaxWidth - 1;
    top = store_up[x];
    mid = store_lo[x];
    store_up[x] = mid;
    store_lo[x] = px;
    for (int i = 0; i < 6; i++) win[i] = win[i+3];
    win[6] = top;
    win[7] = mid;
    win[8] = px;
    last = (irow > 1) || (irow == 1 && icol >= 1);
    icol++;
    if (icol >= w) begin
      icol = 0;
      if (irow < RowCap) irow++;
    end
    if (!last) return 0;
    cols[0] = ocol == 0 ? 1 : 0;
    cols[1] = 1;
    cols[2] = ocol >= w - 1 ? 1 : 2;
    rows[0] = orow == 0 ? 1 : 0;
    rows[1] = 1;
    rows[2] = orow >= h - 1 ? 1 : 2;
    regs[0] = coef_l;
    regs[1] = coef_m;
    regs[2] = coef_r;
    for (int c = 0; c < 3; c++) begin
      if (h < 6) begin
        ch[c] = win[4][16-8*c +: 8];
      end else begin
        s = 0;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            s += longint'(win[cols[i]*3 + rows[j]][16-8*c +: 8])
                 * longint'($signed(regs[i][j*CoefBits +: CoefBits]));
        if (s < 0) ch[c] = 8'd0;
        else if ((s >>> FracBits) > 255) ch[c] = 8'd255;
        else ch[c] = 8'(s >>> FracBits);
      end
    end
    last = orow >= h - 1 && ocol >= w - 1;
    res = '{ch[0], ch[1], ch[2], last};
    if (last) begin
      icol = 0; irow = 0; ocol = 0; orow = 0;
    end else begin
      ocol++;
      if (ocol >= w) begin
        ocol = 0;
        if (orow < RowCap) orow++;
      end
    end
    return 1;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [47:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  cur_w = val[11:0];
      REG_HEIGHT: cur_h = val[12:0];
      REG_COEF_L: coef_l = val;
      REG_COEF_M: coef_m = val;
      REG_COEF_R: coef_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one input transaction; has_exp overrides the predicted result
  task automatic send(input bit kind, input logic [23:0] pix, input bit has_exp, input res_t exp);
    res_t r;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 15) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    {in_red_in, in_green_in, in_blue_in} = pix;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (conv_step(kind, pix, r)) pixq.push_back(has_exp ? exp : r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pixq.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic run_frame(input int w, input int h);
    for (int i = 0; i < w * h; i++) begin
      if (w * h > 40 && i == w * h / 2 && !long_hold && !quiet) long_hold = 1;
      send((i > 0 && $urandom_range(0, 31) == 0) ? KIND_FLUSH : KIND_PIXEL,
           24'($urandom()), 0, '0);
    end
    for (int i = 0; i <= w; i++)
      send($urandom_range(0, 9) == 0 ? KIND_PIXEL : KIND_FLUSH, 24'($urandom()), 0, '0);
    drain();
  endtask

  function automatic logic [47:0] rand_coef(input int mode);
    logic [47:0] v;
    v = 48'({$urandom(), $urandom()});
    if (mode == 0) begin
      for (int k = 0; k < 3; k++)
        v[k*16 +: 16] = 16'($signed($urandom_range(0, 1024)) - 384);
    end
    return v;
  endfunction

  // receiver side
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold == 1) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pixq.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %h %h %b",
          out_red_out, out_green_out, out_blue_out, out_frame_last);
      end else begin
        res_t e;
        e = pixq.pop_front();
        if ({out_red_out, out_green_out, out_blue_out, out_frame_last} !== e) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %h %h %h %b got %h %h %h %b",
            e.red, e.green, e.blue, e.last,
            out_red_out, out_green_out, out_blue_out, out_frame_last);
        end
      end
    end
  end

  initial begin
    #8000000;
    $display("rgb_conv3x3_edge_clamp_tb failed");
    $finish;
  end

  initial begin
    row_t dir_tab[8];
    int w, h, wr, hr;
    for (int i = 0; i < MaxWidth; i++) begin
      store_up[i] = '0;
      store_lo[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    icol = 0; irow = 0; ocol = 0; orow = 0;
    cur_w = 12'd640; cur_h = 13'd480;
    coef_l = '0; coef_m = COEF_ID; coef_r = '0;
    dir_tab = '{
      '{KIND_FLUSH, 8'h00, 8'h00, 8'h00, 0, '0},
      '{KIND_PIXEL, 8'h00, 8'h00, 8'h00, 0, '0},
      '{KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, '0},
      '{KIND_PIXEL, 8'h55, 8'hAA, 8'h0F, 0, '0},
      '{KIND_PIXEL, 8'h80, 8'h01, 8'hFE, 1, '{8'h00, 8'h00, 8'h00, 1'b0}},
      '{KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
      '{KIND_PIXEL, 8'h12, 8'h34, 8'h56, 1, '{8'h55, 8'hAA, 8'h0F, 1'b0}},
      '{KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1, '{8'h80, 8'h01, 8'hFE, 1'b1}}
    };
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // 2x2 pass-through frame, results known by eye
    cfg_write(REG_WIDTH, 48'd2);
    cfg_write(REG_HEIGHT, 48'd2);
    foreach (dir_tab[i])
      send(dir_tab[i].kind, {dir_tab[i].r, dir_tab[i].g, dir_tab[i].b},
           dir_tab[i].has_exp, dir_tab[i].exp);
    drain();

    // coefficient extremes on a small filtered frame
    cfg_write(REG_WIDTH, 48'd3);
    cfg_write(REG_HEIGHT, 48'd6);
    cfg_write(REG_COEF_L, 48'h7FFF_7FFF_7FFF);
    cfg_write(REG_COEF_M, 48'h8000_8000_8000);
    cfg_write(REG_COEF_R, 48'hFFFF_FFFF_FFFF);
    run_frame(3, 6);
    cfg_write(REG_COEF_L, '0);
    cfg_write(REG_COEF_M, COEF_ID);
    cfg_write(REG_COEF_R, '0);
    run_frame(3, 6);

    // size extremes: zero acts as one, then a tall and a wide frame
    cfg_write(REG_WIDTH, 48'd0);
    cfg_write(REG_HEIGHT, 48'd0);
    run_frame(1, 1);
    cfg_write(REG_WIDTH, 48'd1);
    cfg_write(REG_HEIGHT, 48'd12);
    run_frame(1, 12);
    cfg_write(REG_WIDTH, 48'd40);
    cfg_write(REG_HEIGHT, 48'd1);
    run_frame(40, 1);

    while (items_sent < 1300) begin
      if (items_sent > 1100) quiet = 1;
      w = $urandom_range(1, 9);
      h = $urandom_range(0, 3) == 0 ? $urandom_range(1, 5) : $urandom_range(6, 12);
      wr = w;
      hr = h;
      cfg_write(REG_WIDTH, 48'(wr));
      cfg_write(REG_HEIGHT, 48'(hr));
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(REG_COEF_L, rand_coef($urandom_range(0, 1)));
        cfg_write(REG_COEF_M, $urandom_range(0, 1) ? COEF_ID : rand_coef(0));
        cfg_write(REG_COEF_R, rand_coef($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 7) == 0) send(KIND_FLUSH, '0, 0, '0);
      run_frame(w, h);
    end

    if (errors == 0) $display("rgb_conv3x3_edge_clamp_tb passed");
    else $display("rgb_conv3x3_edge_clamp_tb failed");
    $finish;
  end
endmodule
`default_nettype wire
